// ----- rtl/hdc_pkg.sv -----
// ----------------------------------------------------------------------------
// hdc_pkg: shared types and constants for the humidity drying controller
// Field widths, register indexes, reset values and the state/result records.
// ----------------------------------------------------------------------------
package hdc_pkg;

  localparam int unsigned HumW     = 10;
  localparam int unsigned LostW    = 8;
  localparam int unsigned CountW   = 16;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned CfgIdxW  = 2;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegHighThreshold = 2'd0;
  localparam logic [CfgIdxW-1:0] RegLowThreshold  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegHeatTimeLimit = 2'd2;

  // register reset values
  localparam logic [HumW-1:0]   HighThresholdRst = 10'd500;
  localparam logic [HumW-1:0]   LowThresholdRst  = 10'd400;
  localparam logic [CountW-1:0] HeatTimeLimitRst = 16'd5400;

  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  typedef struct packed {
    logic [HumW-1:0]   high_threshold;
    logic [HumW-1:0]   low_threshold;
    logic [CountW-1:0] heat_time_limit;
  } hdc_cfg_t;

  typedef struct packed {
    logic              seen_high;
    logic              fell_low;
    logic              heating;
    logic              paused;
    logic              timing;
    logic              heater;
    logic [CountW-1:0] count;
  } hdc_state_t;

  typedef struct packed {
    logic              heater_on;
    logic              cycle_done;
    logic [CountW-1:0] elapsed;
  } hdc_result_t;

endpackage

// ----- rtl/hdc_if.sv -----
// ----------------------------------------------------------------------------
// hdc channel interfaces
// Valid/ready channels for sample items and result items.
// ----------------------------------------------------------------------------
interface hdc_sample_if;
  logic                           valid;
  logic                           ready;
  logic [hdc_pkg::HumW-1:0]       humidity;
  logic [hdc_pkg::LostW-1:0]      lost_samples;

  modport source (output valid, output humidity, output lost_samples, input ready);
  modport sink   (input valid, input humidity, input lost_samples, output ready);
endinterface

interface hdc_result_if;
  logic                           valid;
  logic                           ready;
  logic                           heater_on;
  logic                           cycle_done;
  logic [hdc_pkg::CountW-1:0]     elapsed;

  modport source (output valid, output heater_on, output cycle_done, output elapsed,
                  input ready);
  modport sink   (input valid, input heater_on, input cycle_done, input elapsed,
                  output ready);
endinterface

// ----- rtl/hdc_step.sv -----
// ----------------------------------------------------------------------------
// hdc_step: per-sample update of the drying cycle
// Phase flags, saturating tick count, heater control and timeout.
// ----------------------------------------------------------------------------
module hdc_step (
  input  hdc_pkg::hdc_cfg_t            cfg_i,
  input  hdc_pkg::hdc_state_t          state_i,
  input  logic [hdc_pkg::HumW-1:0]     humidity_i,
  input  logic [hdc_pkg::LostW-1:0]    lost_samples_i,
  output hdc_pkg::hdc_state_t          state_o,
  output hdc_pkg::hdc_result_t         result_o
);

  logic                          above_high;
  logic                          above_low;
  logic                          below_low;
  logic [hdc_pkg::CountW:0]      sum;

  assign above_high = humidity_i > cfg_i.high_threshold;
  assign above_low  = humidity_i > cfg_i.low_threshold;
  assign below_low  = humidity_i < cfg_i.low_threshold;
  assign sum = {1'b0, state_i.count} + {{hdc_pkg::CountW{1'b0}}, 1'b1}
             + {{(hdc_pkg::CountW + 1 - hdc_pkg::LostW){1'b0}}, lost_samples_i};

  always_comb begin
    hdc_pkg::hdc_state_t s;
    logic                done;
    s    = state_i;
    done = 1'b0;

    // arm, then start heating
    if (above_high) begin
      s.seen_high = 1'b1;
    end else if (s.seen_high && below_low) begin
      s.heating  = 1'b1;
      s.fell_low = 1'b1;
    end

    // pause / resume
    if (above_low && s.heating) begin
      s.paused  = 1'b1;
      s.heating = 1'b0;
    end else if (s.paused && s.seen_high && s.fell_low && below_low) begin
      s.paused  = 1'b0;
      s.heating = 1'b1;
    end

    // count on the timing flag held before this sample
    if (state_i.timing) begin
      s.count = sum[hdc_pkg::CountW] ? hdc_pkg::CountMax : sum[hdc_pkg::CountW-1:0];
    end

    if (s.seen_high || s.fell_low || s.heating || s.paused) begin
      if (s.heating && s.fell_low && s.seen_high) begin
        s.heater = 1'b1;
        s.timing = 1'b1;
      end else if (s.paused && s.fell_low && s.seen_high) begin
        s.heater = 1'b0;
        s.timing = 1'b0;
      end
      // timeout ends the cycle
      if ((s.count > cfg_i.heat_time_limit) && s.heating) begin
        s    = '0;
        done = 1'b1;
      end
    end

    state_o             = s;
    result_o.heater_on  = s.heater;
    result_o.cycle_done = done;
    result_o.elapsed    = s.count;
  end

endmodule

// ----- rtl/humidity_drying_controller_top.sv -----
// ----------------------------------------------------------------------------
// humidity_drying_controller_top: humidity-driven drying cycle controller
// Input register, single-pass update logic, result register.
// ----------------------------------------------------------------------------
// One humidity sample item is taken per cycle when the block is not stalled:
// an accepted item sits in the input register, is run through the update logic
// (threshold compares and one saturating 17-bit add) and lands in the result
// register once that register is empty or its result is being taken, where it
// is offered; items stream at one per clock while the result side takes them.
// The sample side keeps moving while a result waits, as long as the input
// register is free or drains into the result register in the same cycle.
// Thresholds and the heat time limit are written through the plain write
// port and must only be changed while no item is in flight. The controller
// state (phase flags, tick count, heater) is updated as each item enters
// the result register.
module humidity_drying_controller_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  hdc_sample_if.sink                     in_i,
  hdc_result_if.source                   out_o,
  input  logic                           cfg_we_i,
  input  logic [hdc_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [hdc_pkg::CfgDataW-1:0]   cfg_wdata_i
);

  // configuration registers
  hdc_pkg::hdc_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.high_threshold  <= hdc_pkg::HighThresholdRst;
      cfg_q.low_threshold   <= hdc_pkg::LowThresholdRst;
      cfg_q.heat_time_limit <= hdc_pkg::HeatTimeLimitRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        hdc_pkg::RegHighThreshold: cfg_q.high_threshold  <= cfg_wdata_i[hdc_pkg::HumW-1:0];
        hdc_pkg::RegLowThreshold:  cfg_q.low_threshold   <= cfg_wdata_i[hdc_pkg::HumW-1:0];
        hdc_pkg::RegHeatTimeLimit: cfg_q.heat_time_limit <= cfg_wdata_i;
        default: ; // unmapped index: ignored
      endcase
    end
  end

  // input register
  logic                           in_valid_q;
  logic [hdc_pkg::HumW-1:0]       hum_q;
  logic [hdc_pkg::LostW-1:0]      lost_q;
  logic                           advance;
  logic                           in_ready;

  // result register
  logic                           out_valid_q;
  hdc_pkg::hdc_result_t           res_q;
  hdc_pkg::hdc_result_t           res_d;

  // controller state
  hdc_pkg::hdc_state_t            st_q;
  hdc_pkg::hdc_state_t            st_d;

  assign advance  = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_ready = !in_valid_q || advance;
  assign in_i.ready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_i.valid) begin
      hum_q  <= in_i.humidity;
      lost_q <= in_i.lost_samples;
    end
  end

  hdc_step u_step (
    .cfg_i          (cfg_q),
    .state_i        (st_q),
    .humidity_i     (hum_q),
    .lost_samples_i (lost_q),
    .state_o        (st_d),
    .result_o       (res_d)
  );

  // state moves only when an item goes into the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (advance) begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || out_o.ready) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.heater_on  = res_q.heater_on;
  assign out_o.cycle_done = res_q.cycle_done;
  assign out_o.elapsed    = res_q.elapsed;

  // -------------------------------------------------------------------------
  // assertions
  // -------------------------------------------------------------------------

  // heater only runs while the cycle is being timed
  a_heater_timing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.heater |-> st_q.timing)
    else $error("heater on without timing");

  // tick count only moves when timing was set, or is cleared by a timeout
  a_count_gated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(st_q.timing) |-> (st_q.count == $past(st_q.count)) || (st_q.count == '0))
    else $error("tick count moved while not timing");

  // a timeout result reports the heater off and the count cleared
  a_done_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.cycle_done) |-> (!res_q.heater_on && (res_q.elapsed == '0)))
    else $error("cycle end result not cleared");

  // a held input item is not lost while the result side stalls
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> in_valid_q)
    else $error("input item dropped");

endmodule

// ----- dv/humidity_drying_controller_top_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// humidity_drying_controller_top_test: self-checking bench for the controller
// Streams humidity sample items through the valid/ready channel, predicts the
// heater/cycle/elapsed result of each accepted item in a behavioural copy of
// the controller, and compares every result item field by field, in order.
// ----------------------------------------------------------------------------
module humidity_drying_controller_top_test;
  import hdc_pkg::*;

  // not a register: writes to this index must be ignored by the block
  localparam logic [CfgIdxW-1:0] RegUnused = 2'd3;

  localparam int unsigned HoldCycles  = 300;   // long receiver hold-off
  localparam int unsigned StallLimit  = 4000;  // cycles with nothing accepted
  localparam int unsigned PhaseCount  = 8;
  localparam int unsigned PhaseItems  = 165;
  localparam int unsigned DrainCycles = 8;     // drain margin after the last result

  typedef enum logic [1:0] {StallNone, StallPattern, StallHeavy} stall_mode_e;

  logic                clk;
  logic                rst_ni;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_wdata;

  hdc_sample_if smp_if ();
  hdc_result_if res_if ();

  humidity_drying_controller_top i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .in_i        (smp_if),
    .out_o       (res_if),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  // --------------------------------------------------------------------------
  // Behavioural copy of the controller: registers and state
  // --------------------------------------------------------------------------
  hdc_cfg_t    cfg_model;
  hdc_state_t  ctl_model;
  hdc_result_t expected_results[$];

  int unsigned mismatch_count = 0;
  int unsigned items_sent     = 0;
  int unsigned burst_left     = 0;
  bit          steady_send    = 1'b0;  // no sender gaps while set
  bit          hold_request   = 1'b0;  // asks the receiver for a long hold-off

  // One sample through the drying state machine. The count advances on the
  // timing flag as it stood before this item; timing is then re-derived.
  function automatic hdc_result_t step_controller(input logic [HumW-1:0]  hum,
                                                  input logic [LostW-1:0] lost_cnt);
    hdc_result_t          res;
    logic [CountW:0]      sum;
    logic                 done;
    done = 1'b0;

    // arm on a high reading, start heating on a later low one
    if (hum > cfg_model.high_threshold) begin
      ctl_model.seen_high = 1'b1;
    end else if (ctl_model.seen_high && hum < cfg_model.low_threshold) begin
      ctl_model.heating  = 1'b1;
      ctl_model.fell_low = 1'b1;
    end

    // pause above the low threshold, resume below it
    if (hum > cfg_model.low_threshold && ctl_model.heating) begin
      ctl_model.paused  = 1'b1;
      ctl_model.heating = 1'b0;
    end else if (ctl_model.paused && ctl_model.seen_high && ctl_model.fell_low &&
                 hum < cfg_model.low_threshold) begin
      ctl_model.paused  = 1'b0;
      ctl_model.heating = 1'b1;
    end

    // saturating tick count
    if (ctl_model.timing) begin
      sum = {1'b0, ctl_model.count} + (CountW+1)'(1) + (CountW+1)'(lost_cnt);
      ctl_model.count = (sum > {1'b0, CountMax}) ? CountMax : sum[CountW-1:0];
    end

    // heater: untouched while every phase flag is clear
    if (ctl_model.seen_high || ctl_model.fell_low || ctl_model.heating ||
        ctl_model.paused) begin
      if (ctl_model.heating && ctl_model.fell_low && ctl_model.seen_high) begin
        ctl_model.heater = 1'b1;
        ctl_model.timing = 1'b1;
      end else if (ctl_model.paused && ctl_model.fell_low && ctl_model.seen_high) begin
        ctl_model.heater = 1'b0;
        ctl_model.timing = 1'b0;
      end
      // time-out ends the whole cycle
      if (ctl_model.count > cfg_model.heat_time_limit && ctl_model.heating) begin
        ctl_model = '0;
        done      = 1'b1;
      end
    end

    res.heater_on  = ctl_model.heater;
    res.cycle_done = done;
    res.elapsed    = ctl_model.count;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Clock and reset
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Sample side: one item per call, bursts with random gaps between them
  // --------------------------------------------------------------------------
  task automatic send_sample(input logic [HumW-1:0] hum, input logic [LostW-1:0] lost_cnt);
    int unsigned gap;
    @(negedge clk);
    if (!steady_send) begin
      if (burst_left == 0) begin
        // mostly short bursts, now and then a long stretch without a gap
        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 150)
                                                 : $urandom_range(1, 20);
        gap = $urandom_range(1, 6);
        smp_if.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left--;
    end
    smp_if.valid        = 1'b1;
    smp_if.humidity     = hum;
    smp_if.lost_samples = lost_cnt;
    do @(posedge clk); while (!smp_if.ready);
    expected_results.push_back(step_controller(hum, lost_cnt));
    items_sent++;
  endtask

  // Sender pauses until every outstanding result item has come back.
  task automatic wait_results_done();
    @(negedge clk);
    smp_if.valid = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // Register write; the block must be idle (caller drains first).
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(negedge clk);
    smp_if.valid = 1'b0;
    cfg_we       = 1'b1;
    cfg_idx      = idx;
    cfg_wdata    = data;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      RegHighThreshold: cfg_model.high_threshold  = data[HumW-1:0];
      RegLowThreshold:  cfg_model.low_threshold   = data[HumW-1:0];
      RegHeatTimeLimit: cfg_model.heat_time_limit = data[CountW-1:0];
      default: ;
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Sample pickers relative to the current thresholds
  // --------------------------------------------------------------------------
  function automatic logic [HumW-1:0] hum_above_high();
    if (cfg_model.high_threshold >= 10'd1023) return 10'd1023;
    return HumW'($urandom_range(cfg_model.high_threshold + 1, 1023));
  endfunction

  function automatic logic [HumW-1:0] hum_below_low();
    if (cfg_model.low_threshold == 0) return '0;
    return HumW'($urandom_range(0, cfg_model.low_threshold - 1));
  endfunction

  // between the thresholds, hitting each one exactly now and then
  function automatic logic [HumW-1:0] hum_between();
    case ($urandom_range(0, 3))
      0:       return cfg_model.low_threshold;
      1:       return cfg_model.high_threshold;
      default: return HumW'($urandom_range(cfg_model.low_threshold,
                                           cfg_model.high_threshold));
    endcase
  endfunction

  function automatic logic [LostW-1:0] pick_lost();
    if ($urandom_range(0, 99) < 85) return LostW'($urandom_range(0, 3));
    return LostW'($urandom_range(0, 255));
  endfunction

  // Arm, drop low, heat with the odd pause, mostly long enough to time out.
  task automatic send_drying_cycle();
    int unsigned heat_len;
    repeat ($urandom_range(1, 3)) send_sample(hum_above_high(), pick_lost());
    if ($urandom_range(0, 4) == 0) send_sample(hum_between(), pick_lost());
    heat_len = $urandom_range(1, 40);
    repeat (heat_len) begin
      if ($urandom_range(0, 99) < 12) begin
        send_sample(($urandom_range(0, 2) == 0) ? hum_above_high() : hum_between(),
                    pick_lost());
      end else begin
        send_sample(hum_below_low(), pick_lost());
      end
    end
  endtask

  task automatic send_noise();
    repeat ($urandom_range(5, 20)) begin
      send_sample(HumW'($urandom_range(0, 1023)), LostW'($urandom_range(0, 255)));
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset thresholds: all flags clear, equal readings, field extremes, arming.
  task automatic test_field_extremes();
    send_sample(10'd0, 8'd0);       // idle, outputs hold
    send_sample(10'd500, 8'd0);     // equal to high: not above
    send_sample(10'd400, 8'd0);     // equal to low: not below
    send_sample(10'd1000, 8'd255);  // arms
    send_sample(10'd400, 8'd0);     // armed, equal to low: nothing starts
    send_sample(10'd1023, 8'd128);  // out-of-range sample, compared as given
    send_sample(10'd0, 8'd255);     // heating starts, heater on
  endtask

  task automatic test_pause_resume();
    send_sample(10'd450, 8'd1);     // above low: pause
    send_sample(10'd400, 8'd0);     // equal: stays paused
    send_sample(10'd399, 8'd7);     // resume
    send_sample(10'd1023, 8'd0);    // above high also pauses
    send_sample(10'd0, 8'd255);     // resume
  endtask

  task automatic test_timeout();
    wait_results_done();
    write_reg(RegHeatTimeLimit, 16'd3);
    send_sample(10'd0, 8'd0);
    send_sample(10'd10, 8'd2);
    send_sample(10'd20, 8'd0);
    send_sample(10'd30, 8'd0);
  endtask

  task automatic test_threshold_extremes();
    wait_results_done();
    write_reg(RegHighThreshold, 16'hFFFF);  // top bits dropped: 1023
    write_reg(RegLowThreshold, 16'hFC00);   // top bits dropped: 0
    write_reg(RegUnused, 16'h0123);
    send_sample(10'd1023, 8'd0);
    send_sample(10'd0, 8'd0);
    wait_results_done();
    write_reg(RegHighThreshold, 16'd0);
    write_reg(RegLowThreshold, 16'd1000);
    write_reg(RegHeatTimeLimit, 16'd0);
    send_sample(10'd1, 8'd0);
    send_sample(10'd999, 8'd3);
    send_sample(10'd1000, 8'd0);
    send_sample(10'd0, 8'd1);
    send_sample(10'd0, 8'd0);
  endtask

  // Top limit: the count runs high with no timeout, then a zero limit ends it.
  task automatic test_count_saturation();
    wait_results_done();
    write_reg(RegHighThreshold, 16'd500);
    write_reg(RegLowThreshold, 16'd400);
    write_reg(RegHeatTimeLimit, 16'hFFFF);
    send_sample(10'd600, 8'd0);
    send_sample(10'd100, 8'd0);
    repeat (260) begin
      send_sample(HumW'($urandom_range(0, 399)), LostW'($urandom_range(224, 255)));
    end
    wait_results_done();
    write_reg(RegHeatTimeLimit, 16'd0);
    send_sample(10'd0, 8'd0);
  endtask

  // Receiver holds off while the sender keeps offering: the block fills up.
  task automatic test_backpressure();
    wait_results_done();
    hold_request = 1'b1;
    steady_send  = 1'b1;
    repeat (2) send_drying_cycle();
    steady_send  = 1'b0;
    wait_results_done();
  endtask

  task automatic write_random_config();
    logic [HumW-1:0]   high_val;
    logic [HumW-1:0]   low_val;
    logic [CountW-1:0] limit_val;
    wait_results_done();
    high_val = HumW'($urandom_range(200, 1000));
    if ($urandom_range(0, 9) == 0) high_val = ($urandom_range(0, 1) != 0) ? 10'd1023 : 10'd0;
    low_val = HumW'($urandom_range(0, high_val));
    if ($urandom_range(0, 9) == 0) low_val = HumW'($urandom_range(0, 1023));
    case ($urandom_range(0, 9))
      0:       limit_val = ($urandom_range(0, 1) != 0) ? CountMax : '0;
      1, 2:    limit_val = CountW'($urandom_range(0, 65535));
      default: limit_val = CountW'($urandom_range(0, 200));
    endcase
    // spare upper bits must be dropped by the block
    write_reg(RegHighThreshold, {6'($urandom_range(0, 63)), high_val});
    write_reg(RegLowThreshold, {6'($urandom_range(0, 63)), low_val});
    write_reg(RegHeatTimeLimit, limit_val);
    if ($urandom_range(0, 9) == 0) write_reg(RegUnused, CfgDataW'($urandom));
  endtask

  task automatic test_random_cycles();
    int unsigned phase_end;
    for (int unsigned phase = 0; phase < PhaseCount; phase++) begin
      write_random_config();
      if (phase == 3) test_backpressure();
      phase_end = items_sent + PhaseItems;
      while (items_sent < phase_end) begin
        if ($urandom_range(0, 9) < 7) send_drying_cycle();
        else send_noise();
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_ni              = 1'b0;
    cfg_we              = 1'b0;
    cfg_idx             = '0;
    cfg_wdata           = '0;
    smp_if.valid        = 1'b0;
    smp_if.humidity     = '0;
    smp_if.lost_samples = '0;
    cfg_model.high_threshold  = HighThresholdRst;
    cfg_model.low_threshold   = LowThresholdRst;
    cfg_model.heat_time_limit = HeatTimeLimitRst;
    ctl_model = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_ni = 1'b1;

    test_field_extremes();
    test_pause_resume();
    test_timeout();
    test_threshold_extremes();
    test_count_saturation();
    test_random_cycles();

    wait_results_done();
    repeat (DrainCycles) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("humidity_drying_controller_top: match");
    end else begin
      $display("humidity_drying_controller_top: mismatch");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result side: stall pattern of its own, plus the long hold-off on request
  // --------------------------------------------------------------------------
  initial begin : result_stall
    stall_mode_e mode;
    logic [31:0] pattern;
    int unsigned mode_left;
    int unsigned hold_left;
    mode      = StallNone;
    pattern   = '1;
    mode_left = 0;
    hold_left = 0;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_left    = HoldCycles;
        hold_request = 1'b0;
      end
      if (mode_left == 0) begin
        mode      = stall_mode_e'($urandom_range(0, 2));
        pattern   = $urandom;
        mode_left = $urandom_range(32, 128);
      end
      mode_left--;
      if (hold_left != 0) begin
        hold_left--;
        res_if.ready = 1'b0;
      end else begin
        case (mode)
          StallNone:    res_if.ready = 1'b1;
          StallPattern: res_if.ready = pattern[mode_left[4:0]];
          default:      res_if.ready = ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Compare each accepted result item with the oldest prediction.
  initial begin : result_checker
    hdc_result_t want;
    forever begin
      @(posedge clk);
      if (rst_ni && res_if.valid && res_if.ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result item: heater_on %0b cycle_done %0b elapsed %0d",
                 res_if.heater_on, res_if.cycle_done, res_if.elapsed);
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          if (res_if.heater_on !== want.heater_on) begin
            $error("heater_on: expected %0b, actual %0b", want.heater_on, res_if.heater_on);
            mismatch_count++;
          end
          if (res_if.cycle_done !== want.cycle_done) begin
            $error("cycle_done: expected %0b, actual %0b", want.cycle_done,
                   res_if.cycle_done);
            mismatch_count++;
          end
          if (res_if.elapsed !== want.elapsed) begin
            $error("elapsed: expected %0d, actual %0d", want.elapsed, res_if.elapsed);
            mismatch_count++;
          end
        end
      end
    end
  end

  // Watchdog: too long without any item moving on either side.
  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if ((smp_if.valid && smp_if.ready) || (res_if.valid && res_if.ready) || cfg_we ||
          !rst_ni) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= StallLimit) begin
        $error("no item accepted for %0d cycles", quiet_cycles);
        $display("humidity_drying_controller_top: mismatch");
        $finish;
      end
    end
  end

endmodule

// ----- filelist.f -----
rtl/hdc_pkg.sv
rtl/hdc_if.sv
rtl/hdc_step.sv
rtl/humidity_drying_controller_top.sv
dv/humidity_drying_controller_top_test.sv
